// ----- rtl/line_endpoint_axis_snap_macros.svh -----
// Assertion helpers for the checker of this block.
`ifndef LINE_ENDPOINT_AXIS_SNAP_MACROS_SVH
`define LINE_ENDPOINT_AXIS_SNAP_MACROS_SVH

// same-cycle implication, disabled in reset
`define LES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define LES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/les_pkg.sv -----
`default_nettype none
package les_pkg;

  localparam int DIV_QBITS  = 62;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = DIV_QBITS / DIV_STEP;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [62:0] OFS_LIMIT = 63'd1 << 62;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               vert;
    logic               horz;
    logic [32:0]        mag_dx;
    logic [32:0]        mag_dy;
    logic [32:0]        mag_ocx;
    logic [32:0]        mag_ocy;
    logic               neg_a;
    logic               neg_b;
  } les_item_t;

endpackage
`default_nettype wire

// ----- rtl/les_front.sv -----
`default_nettype none
module les_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_cursor_x,
  input  logic signed [31:0] in_cursor_y,
  input  logic               fifo_full,
  output logic               push,
  output les_pkg::les_item_t item
);
  import les_pkg::*;

  logic signed [32:0] dx, dy, ocx, ocy;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready;

  assign dx  = {in_end_x[31], in_end_x} - {in_start_x[31], in_start_x};
  assign dy  = {in_end_y[31], in_end_y} - {in_start_y[31], in_start_y};
  assign ocx = {in_cursor_x[31], in_cursor_x} - {in_start_x[31], in_start_x};
  assign ocy = {in_cursor_y[31], in_cursor_y} - {in_start_y[31], in_start_y};

  always_comb begin
    item.sx      = in_start_x;
    item.sy      = in_start_y;
    item.ex      = in_end_x;
    item.ey      = in_end_y;
    item.cx      = in_cursor_x;
    item.cy      = in_cursor_y;
    item.vert    = (dx == '0);
    item.horz    = (dy == '0);
    item.mag_dx  = mag33(dx);
    item.mag_dy  = mag33(dy);
    item.mag_ocx = mag33(ocx);
    item.mag_ocy = mag33(ocy);
    // sign of dy*ocx/dx and of dx*ocy/dy
    item.neg_a   = dy[32] ^ ocx[32] ^ dx[32];
    item.neg_b   = dx[32] ^ ocy[32] ^ dy[32];
  end

endmodule
`default_nettype wire

// ----- rtl/les_fifo.sv -----
`default_nettype none
module les_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  les_pkg::les_item_t wr_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output les_pkg::les_item_t rd_item
);
  import les_pkg::*;

  les_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign full    = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/les_back.sv -----
`default_nettype none
module les_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               bidir,
  input  logic               q_valid,
  input  les_pkg::les_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_start_x,
  output logic signed [31:0] out_new_start_y,
  output logic signed [31:0] out_new_end_x,
  output logic signed [31:0] out_new_end_y,
  output logic               out_moved_end,
  output logic               out_saturated
);
  import les_pkg::*;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic               vert;
    logic               horz;
  } side_t;

  typedef struct packed {
    logic [32:0]          r;
    logic [DIV_QBITS-1:0] nq;   // numerator bits shift out, quotient bits shift in
    logic [32:0]          d;
    logic                 big;
    logic                 neg;
  } div_t;

  function automatic div_t div_init(input logic [65:0] n, input logic [32:0] d,
                                    input logic neg);
    div_t y;
    y.r   = {29'd0, n[65:62]};
    y.nq  = n[DIV_QBITS-1:0];
    y.d   = d;
    y.big = ({29'd0, n[65:62]} >= d);
    y.neg = neg;
    return y;
  endfunction

  function automatic div_t div_step(input div_t x);
    div_t        y;
    logic [33:0] t;
    y = x;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {y.r, y.nq[DIV_QBITS-1]};
      if (t >= {1'b0, y.d}) begin
        y.r  = 33'(t - {1'b0, y.d});
        y.nq = {y.nq[DIV_QBITS-2:0], 1'b1};
      end else begin
        y.r  = t[32:0];
        y.nq = {y.nq[DIV_QBITS-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  // round half away from zero, held at 2^62, signed
  function automatic logic signed [63:0] div_finish(input div_t x);
    logic        rb;
    logic [62:0] ofs;
    rb  = ({x.r, 1'b0} >= {1'b0, x.d});
    ofs = x.big ? OFS_LIMIT : ({1'b0, x.nq} + 63'(rb));
    return x.neg ? -$signed({1'b0, ofs}) : $signed({1'b0, ofs});
  endfunction

  function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] abs33(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return m[31:0];
  endfunction

  function automatic logic [32:0] clip64(input logic signed [63:0] v);
    // {clipped flag, value}
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  logic en;

  // stage 0: products
  logic        s0_v_r;
  side_t       s0_sb_r;
  logic [65:0] s0_pa_r, s0_pb_r;
  logic [32:0] s0_da_r, s0_db_r;
  logic        s0_na_r, s0_nb_r;

  // divider chain
  logic [DIV_STAGES:0] dv_r;
  side_t               dsb_r  [DIV_STAGES+1];
  div_t                diva_r [DIV_STAGES+1];
  div_t                divb_r [DIV_STAGES+1];

  // post stages
  logic               r1_v_r, r2_v_r, r3_v_r, r4_v_r, r5_v_r, out_v_r;
  side_t              r1_sb_r, r2_sb_r, r3_sb_r, r4_sb_r, r5_sb_r;
  logic signed [63:0] r1_va_r, r1_vb_r;
  logic signed [63:0] r2_apx_r, r2_apy_r, r2_bpx_r, r2_bpy_r;
  logic signed [63:0] r3_apx_r, r3_apy_r, r3_bpx_r, r3_bpy_r;
  logic [63:0]        r3_da_r, r3_db_r;
  logic signed [31:0] r4_px_r, r4_py_r, r5_px_r, r5_py_r;
  logic               r4_sat_r, r5_sat_r;
  logic [63:0]        r5_sqsx_r, r5_sqsy_r, r5_sqex_r, r5_sqey_r;
  logic signed [33:0] r5_ox_r, r5_oy_r;

  logic signed [32:0] dsx, dsy, dex, dey;
  logic [32:0]        cpx, cpy, cox, coy;
  logic [64:0]        sum_s, sum_e;
  logic               move_end;

  assign en    = !out_v_r || out_ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      dv_r    <= '0;
      r1_v_r  <= 1'b0;
      r2_v_r  <= 1'b0;
      r3_v_r  <= 1'b0;
      r4_v_r  <= 1'b0;
      r5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r  <= q_valid;
      dv_r    <= {dv_r[DIV_STAGES-1:0], s0_v_r};
      r1_v_r  <= dv_r[DIV_STAGES];
      r2_v_r  <= r1_v_r;
      r3_v_r  <= r2_v_r;
      r4_v_r  <= r3_v_r;
      r5_v_r  <= r4_v_r;
      out_v_r <= r5_v_r;
    end
  end

  // numerators and divisors
  always_ff @(posedge clk) begin
    if (en) begin
      s0_sb_r <= '{q_item.sx, q_item.sy, q_item.ex, q_item.ey, q_item.cx, q_item.cy,
                   q_item.vert, q_item.horz};
      s0_pa_r <= q_item.mag_dy * q_item.mag_ocx;
      s0_pb_r <= q_item.mag_dx * q_item.mag_ocy;
      s0_da_r <= q_item.mag_dx;
      s0_db_r <= q_item.mag_dy;
      s0_na_r <= q_item.neg_a;
      s0_nb_r <= q_item.neg_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsb_r[0]  <= s0_sb_r;
      diva_r[0] <= div_init(s0_pa_r, s0_da_r, s0_na_r);
      divb_r[0] <= div_init(s0_pb_r, s0_db_r, s0_nb_r);
      for (int k = 1; k <= DIV_STAGES; k++) begin
        dsb_r[k]  <= dsb_r[k-1];
        diva_r[k] <= div_step(diva_r[k-1]);
        divb_r[k] <= div_step(divb_r[k-1]);
      end
    end
  end

  // rounding, projections, distances, choice
  always_ff @(posedge clk) begin
    if (en) begin
      r1_sb_r <= dsb_r[DIV_STAGES];
      r1_va_r <= div_finish(diva_r[DIV_STAGES]);
      r1_vb_r <= div_finish(divb_r[DIV_STAGES]);

      r2_sb_r  <= r1_sb_r;
      r2_apx_r <= r1_sb_r.vert ? sx64(r1_sb_r.sx) : sx64(r1_sb_r.cx);
      r2_apy_r <= r1_sb_r.vert ? sx64(r1_sb_r.cy) : sx64(r1_sb_r.sy) + r1_va_r;
      r2_bpx_r <= r1_sb_r.horz ? sx64(r1_sb_r.cx) : sx64(r1_sb_r.sx) + r1_vb_r;
      r2_bpy_r <= r1_sb_r.horz ? sx64(r1_sb_r.sy) : sx64(r1_sb_r.cy);

      // each projection differs from the cursor in one coordinate only
      r3_sb_r  <= r2_sb_r;
      r3_apx_r <= r2_apx_r;
      r3_apy_r <= r2_apy_r;
      r3_bpx_r <= r2_bpx_r;
      r3_bpy_r <= r2_bpy_r;
      r3_da_r  <= r2_sb_r.vert ? abs64(r2_apx_r - sx64(r2_sb_r.cx))
                               : abs64(r2_apy_r - sx64(r2_sb_r.cy));
      r3_db_r  <= r2_sb_r.horz ? abs64(r2_bpy_r - sx64(r2_sb_r.cy))
                               : abs64(r2_bpx_r - sx64(r2_sb_r.cx));

      r4_sb_r  <= r3_sb_r;
      r4_px_r  <= cpx[31:0];
      r4_py_r  <= cpy[31:0];
      r4_sat_r <= cpx[32] | cpy[32];
    end
  end

  always_comb begin
    if (r3_da_r < r3_db_r) begin
      cpx = clip64(r3_apx_r);
      cpy = clip64(r3_apy_r);
    end else begin
      cpx = clip64(r3_bpx_r);
      cpy = clip64(r3_bpy_r);
    end
  end

  // squared distances and mirror point
  assign dsx = {r4_px_r[31], r4_px_r} - {r4_sb_r.sx[31], r4_sb_r.sx};
  assign dsy = {r4_py_r[31], r4_py_r} - {r4_sb_r.sy[31], r4_sb_r.sy};
  assign dex = {r4_px_r[31], r4_px_r} - {r4_sb_r.ex[31], r4_sb_r.ex};
  assign dey = {r4_py_r[31], r4_py_r} - {r4_sb_r.ey[31], r4_sb_r.ey};

  always_ff @(posedge clk) begin
    if (en) begin
      r5_sb_r   <= r4_sb_r;
      r5_px_r   <= r4_px_r;
      r5_py_r   <= r4_py_r;
      r5_sat_r  <= r4_sat_r;
      r5_sqsx_r <= abs33(dsx) * abs33(dsx);
      r5_sqsy_r <= abs33(dsy) * abs33(dsy);
      r5_sqex_r <= abs33(dex) * abs33(dex);
      r5_sqey_r <= abs33(dey) * abs33(dey);
      r5_ox_r   <= {{2{r4_sb_r.sx[31]}}, r4_sb_r.sx} + {{2{r4_sb_r.ex[31]}}, r4_sb_r.ex}
                   - {{2{r4_px_r[31]}}, r4_px_r};
      r5_oy_r   <= {{2{r4_sb_r.sy[31]}}, r4_sb_r.sy} + {{2{r4_sb_r.ey[31]}}, r4_sb_r.ey}
                   - {{2{r4_py_r[31]}}, r4_py_r};
    end
  end

  assign sum_s    = {1'b0, r5_sqsx_r} + {1'b0, r5_sqsy_r};
  assign sum_e    = {1'b0, r5_sqex_r} + {1'b0, r5_sqey_r};
  assign move_end = !(sum_s < sum_e);   // ties move the end
  assign cox      = clip64({{30{r5_ox_r[33]}}, r5_ox_r});
  assign coy      = clip64({{30{r5_oy_r[33]}}, r5_oy_r});

  always_ff @(posedge clk) begin
    if (en) begin
      out_moved_end <= move_end;
      out_saturated <= r5_sat_r | (bidir & (cox[32] | coy[32]));
      if (move_end) begin
        out_new_end_x   <= r5_px_r;
        out_new_end_y   <= r5_py_r;
        out_new_start_x <= bidir ? cox[31:0] : r5_sb_r.sx;
        out_new_start_y <= bidir ? coy[31:0] : r5_sb_r.sy;
      end else begin
        out_new_start_x <= r5_px_r;
        out_new_start_y <= r5_py_r;
        out_new_end_x   <= bidir ? cox[31:0] : r5_sb_r.ex;
        out_new_end_y   <= bidir ? coy[31:0] : r5_sb_r.ey;
      end
    end
  end

  assign out_valid = out_v_r;

endmodule
`default_nettype wire

// ----- rtl/line_endpoint_axis_snap.sv -----
// Line endpoint axis snap.
// Input channel (in_valid/in_ready): one segment (start, end) and a cursor per word,
// all coordinates signed Q16.16. Result channel (out_valid/out_ready): the updated
// segment, which endpoint was moved to the snap point, and a saturation flag.
// cfg_we/cfg_wdata set the bidirectional mode; write it only while the block is idle.
// From input acceptance to out_valid, a word passes through the 31-stage
// restoring divider (two quotient bits per stage) plus multiply and compare stages.
// Throughput: one word per cycle in and out while out_ready stays high.
// Reset (synchronous, rst_n low) empties the queue and the pipeline and clears
// bidirectional mode; in_ready is high right after reset.
// When out_ready is low with a result pending, the whole back pipeline holds; the
// 4-entry queue in front of it keeps taking words until it fills, then in_ready drops.
`default_nettype none
module line_endpoint_axis_snap (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic signed [31:0] in_cursor_x,
  input  logic signed [31:0] in_cursor_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_start_x,
  output logic signed [31:0] out_new_start_y,
  output logic signed [31:0] out_new_end_x,
  output logic signed [31:0] out_new_end_y,
  output logic               out_moved_end,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import les_pkg::*;

  logic      bidir_r;
  logic      fifo_full, fifo_empty, push, pop;
  les_item_t wr_item, rd_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bidir_r <= 1'b0;
    end else if (cfg_we) begin
      bidir_r <= cfg_wdata;
    end
  end

  les_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .in_cursor_x (in_cursor_x),
    .in_cursor_y (in_cursor_y),
    .fifo_full   (fifo_full),
    .push        (push),
    .item        (wr_item)
  );

  les_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .full    (fifo_full),
    .pop     (pop),
    .empty   (fifo_empty),
    .rd_item (rd_item)
  );

  les_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .bidir           (bidir_r),
    .q_valid         (!fifo_empty),
    .q_item          (rd_item),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_start_x (out_new_start_x),
    .out_new_start_y (out_new_start_y),
    .out_new_end_x   (out_new_end_x),
    .out_new_end_y   (out_new_end_y),
    .out_moved_end   (out_moved_end),
    .out_saturated   (out_saturated)
  );

endmodule
`default_nettype wire

// ----- rtl/les_checker.sv -----
`default_nettype none
`include "line_endpoint_axis_snap_macros.svh"
module les_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [31:0] in_start_x,
  input logic signed [31:0] in_start_y,
  input logic signed [31:0] in_end_x,
  input logic signed [31:0] in_end_y,
  input logic signed [31:0] in_cursor_x,
  input logic signed [31:0] in_cursor_y,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_new_start_x,
  input logic signed [31:0] out_new_start_y,
  input logic signed [31:0] out_new_end_x,
  input logic signed [31:0] out_new_end_y,
  input logic               out_moved_end,
  input logic               out_saturated,
  input logic               cfg_we
);

  logic [191:0] in_word;
  logic [129:0] out_word;

  assign in_word  = {in_start_x, in_start_y, in_end_x, in_end_y, in_cursor_x, in_cursor_y};
  assign out_word = {out_new_start_x, out_new_start_y, out_new_end_x, out_new_end_y,
                     out_moved_end, out_saturated};

  // a stalled result word holds
  `LES_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "stalled result changed")

  // a waiting input word holds
  `LES_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_word), "waiting input changed")

  // empty and ready right after reset
  `LES_ASSERT_NOW(a_after_reset, $past(!rst_n), !out_valid && in_ready, "not empty after reset")

  // the queue only fills while the output is stalled
  `LES_ASSERT_NOW(a_ready_drop, $fell(in_ready), $past(out_valid && !out_ready), "in_ready fell without output stall")

  // mode changes only while idle
  `LES_ASSERT_NOW(a_cfg_idle, cfg_we, !out_valid, "mode written with results pending")

endmodule

bind line_endpoint_axis_snap les_checker u_les_checker (.*);
`default_nettype wire

// ----- tb/line_endpoint_axis_snap_tb.sv -----
`default_nettype none
module line_endpoint_axis_snap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] sx, sy, ex, ey, cx, cy;
  } seg_query_t;

  typedef struct {
    logic signed [31:0] nsx, nsy, nex, ney;
    logic               moved_end;
    logic               saturated;
  } snap_result_t;

  typedef struct {
    seg_query_t   q;
    bit           typed;
    snap_result_t res;
  } dir_row_t;

  localparam logic signed [31:0] PMAX = 32'sh7fffffff;
  localparam logic signed [31:0] PMIN = 32'sh80000000;
  localparam longint OFS_CAP = longint'(1) <<< 62;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic signed [31:0] in_cursor_x = '0, in_cursor_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_new_start_x, out_new_start_y, out_new_end_x, out_new_end_y;
  logic out_moved_end, out_saturated;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  line_endpoint_axis_snap dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .in_cursor_x(in_cursor_x), .in_cursor_y(in_cursor_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_new_start_x(out_new_start_x), .out_new_start_y(out_new_start_y),
    .out_new_end_x(out_new_end_x), .out_new_end_y(out_new_end_y),
    .out_moved_end(out_moved_end), .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bit           mirror_mode = 1'b0;
  snap_result_t pending_snaps[$];
  int           mismatches = 0;
  int           words_in = 0;
  int           words_out = 0;
  int           sat_seen = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // round(a*b/d), halves away from zero, magnitude held at 2^62
  function automatic longint axis_offset(longint a, longint b, longint d);
    logic [127:0] num, den, quo, rem;
    bit neg;
    longint mag_q;
    neg = ((a < 0) != (b < 0)) != (d < 0);
    num = 128'(abs64(a)) * 128'(abs64(b));
    den = 128'(abs64(d));
    quo = num / den;
    rem = num % den;
    if (quo >= 128'(OFS_CAP)) mag_q = OFS_CAP;
    else begin
      if (2 * rem >= den) quo = quo + 1;
      mag_q = (quo > 128'(OFS_CAP)) ? OFS_CAP : longint'(quo[63:0]);
    end
    return neg ? -mag_q : mag_q;
  endfunction

  function automatic longint clamp32(longint v, inout bit sat);
    if (v > longint'(PMAX)) begin sat = 1; return longint'(PMAX); end
    if (v < longint'(PMIN)) begin sat = 1; return longint'(PMIN); end
    return v;
  endfunction

  function automatic logic [127:0] dist_sq(longint a, longint b);
    logic [127:0] ma, mb;
    ma = 128'(abs64(a));
    mb = 128'(abs64(b));
    return ma * ma + mb * mb;
  endfunction

  function automatic snap_result_t predict_snap(seg_query_t q);
    longint sx, sy, ex, ey, cx, cy, dx, dy, ax, ay, bx, by, px, py, ox, oy;
    logic [63:0] da, db;
    bit sat, mv;
    snap_result_t r;
    sx = q.sx; sy = q.sy; ex = q.ex; ey = q.ey; cx = q.cx; cy = q.cy;
    dx = ex - sx; dy = ey - sy;
    sat = 0;
    if (dx == 0) begin
      ax = sx; ay = cy; da = abs64(sx - cx);
    end else begin
      ax = cx; ay = sy + axis_offset(dy, cx - sx, dx); da = abs64(ay - cy);
    end
    if (dy == 0) begin
      bx = cx; by = sy; db = abs64(sy - cy);
    end else begin
      by = cy; bx = sx + axis_offset(dx, cy - sy, dy); db = abs64(bx - cx);
    end
    if (da < db) begin px = ax; py = ay; end
    else begin px = bx; py = by; end
    px = clamp32(px, sat);
    py = clamp32(py, sat);
    mv = !(dist_sq(px - sx, py - sy) < dist_sq(px - ex, py - ey));
    ox = sx + ex - px;
    oy = sy + ey - py;
    r.nsx = q.sx; r.nsy = q.sy; r.nex = q.ex; r.ney = q.ey;
    if (mv) begin
      r.nex = 32'(px); r.ney = 32'(py);
      if (mirror_mode) begin r.nsx = 32'(clamp32(ox, sat)); r.nsy = 32'(clamp32(oy, sat)); end
    end else begin
      r.nsx = 32'(px); r.nsy = 32'(py);
      if (mirror_mode) begin r.nex = 32'(clamp32(ox, sat)); r.ney = 32'(clamp32(oy, sat)); end
    end
    r.moved_end = mv;
    r.saturated = sat;
    return r;
  endfunction

  // result monitor
  always @(posedge clk) begin
    snap_result_t e;
    if (rst_n && out_valid && out_ready) begin
      words_out++;
      if (pending_snaps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        e = pending_snaps.pop_front();
        if (e.saturated) sat_seen++;
        if (out_new_start_x !== e.nsx || out_new_start_y !== e.nsy ||
            out_new_end_x !== e.nex || out_new_end_y !== e.ney ||
            out_moved_end !== e.moved_end || out_saturated !== e.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch word %0d: exp %h %h %h %h m%b s%b got %h %h %h %h m%b s%b",
                     words_out, e.nsx, e.nsy, e.nex, e.ney, e.moved_end, e.saturated,
                     out_new_start_x, out_new_start_y, out_new_end_x, out_new_end_y,
                     out_moved_end, out_saturated);
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles <= 0;
    else if (rst_n) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_query(seg_query_t q, bit typed, snap_result_t res);
    @(negedge clk);
    // one idle decision per cycle
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= q.sx; in_start_y <= q.sy; in_end_x <= q.ex; in_end_y <= q.ey;
    in_cursor_x <= q.cx; in_cursor_y <= q.cy;
    do @(posedge clk); while (!in_ready);
    pending_snaps.push_back(typed ? res : predict_snap(q));
    words_in++;
  endtask

  task automatic drain_and_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_snaps.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_mode(bit v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    mirror_mode = v;
  endtask

  function automatic logic signed [31:0] rand_coord(int shape);
    case (shape)
      0: return $urandom;
      1: return $signed($urandom_range(8191)) - 4096;
      2: return ($urandom_range(1)) ? PMAX - $urandom_range(3) : PMIN + $urandom_range(3);
      default: return $signed($urandom_range(2000000)) - 1000000;
    endcase
  endfunction

  function automatic seg_query_t rand_query();
    seg_query_t q;
    int shape, kind;
    shape = $urandom_range(3);
    q.sx = rand_coord(shape); q.sy = rand_coord(shape);
    q.ex = rand_coord(shape); q.ey = rand_coord(shape);
    q.cx = rand_coord($urandom_range(3)); q.cy = rand_coord($urandom_range(3));
    kind = $urandom_range(9);
    case (kind)
      0: q.ex = q.sx;                       // vertical
      1: q.ey = q.sy;                       // horizontal
      2: begin q.ex = q.sx; q.ey = q.sy; end // single point
      3: begin q.ex = q.sx + 1; q.cx = q.sx + 32'sh40000000; end // steep, huge offset
      4: begin q.cx = q.sx; q.cy = q.sy; end
      default: ;
    endcase
    return q;
  endfunction

  dir_row_t     dir_rows[$];
  snap_result_t blank;
  snap_result_t r_zero, r_max, r_min;
  int           ph;

  initial begin
    blank = '{default: '0};
    r_zero = '{nsx: 0, nsy: 0, nex: 0, ney: 0, moved_end: 1, saturated: 0};
    r_max = '{nsx: PMAX, nsy: PMAX, nex: PMAX, ney: PMAX, moved_end: 1, saturated: 0};
    r_min = '{nsx: PMIN, nsy: PMIN, nex: PMIN, ney: PMIN, moved_end: 1, saturated: 0};
    dir_rows = '{
      '{'{0, 0, 0, 0, 0, 0}, 1, r_zero},
      '{'{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}, 1, r_max},
      '{'{PMIN, PMIN, PMIN, PMIN, PMIN, PMIN}, 1, r_min},
      '{'{PMIN, PMIN, PMAX, PMAX, PMAX, PMIN}, 0, blank},
      '{'{PMIN, PMAX, PMAX, PMIN, PMIN, PMIN}, 0, blank},
      '{'{32'h10000, 0, 32'h10000, 32'h50000, 0, 32'h20000}, 0, blank},
      '{'{0, 32'h30000, 32'h70000, 32'h30000, 32'h20000, 0}, 0, blank},
      '{'{32'h10000, 32'h20000, 32'h10000, 32'h20000, 32'h50000, 32'h90000}, 0, blank},
      '{'{0, 0, 1, PMAX, 32'h40000000, 0}, 0, blank},
      '{'{0, 0, PMAX, 1, 0, 32'h40000000}, 0, blank},
      '{'{0, 0, 32'h20000, 32'h20000, 32'h10000, 32'h10000}, 0, blank},
      '{'{0, 0, 32'h20000, 32'h20000, 32'h10000, 0}, 0, blank},
      '{'{0, 0, 3, 2, 1, 0}, 0, blank},
      '{'{PMAX, 0, PMIN, 1, 0, PMIN}, 0, blank},
      '{'{-5, 7, 9, -3, PMAX, PMIN}, 0, blank}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) push_query(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].res);
    drain_and_idle();
    write_mode(1'b1);
    foreach (dir_rows[i]) push_query(dir_rows[i].q, 1'b0, blank);
    drain_and_idle();

    for (ph = 0; ph < 8; ph++) begin
      write_mode(ph[0]);
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 57; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 57; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      for (int n = 0; n < 195; n++) begin
        if (ph == 0 && n == 20) hold_left = 300;
        if (ph == 3 && n == 100) begin
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending_snaps.size() != 0) @(posedge clk);
        end
        push_query(rand_query(), 1'b0, blank);
      end
      drain_and_idle();
    end

    $display("covered %0d words in, %0d out, %0d saturating, both modes, all idle mixes",
             words_in, words_out, sat_seen);
    if (mismatches == 0 && pending_snaps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/les_pkg.sv
rtl/les_front.sv
rtl/les_fifo.sv
rtl/les_back.sv
rtl/line_endpoint_axis_snap.sv
rtl/les_checker.sv
tb/line_endpoint_axis_snap_tb.sv
